[rtl/fwa_pkg.sv]
// ----------------------------------------------------------------------------
// fwa_pkg
// Shared types and codes of the fork waiter arbiter: payload structs, event
// codes, seat status codes and request modes.
// ----------------------------------------------------------------------------
package fwa_pkg;

  localparam int SEAT_W = 4;
  localparam int RING_W = 5;
  localparam int MEAL_OUT_W = 16;
  localparam logic [RING_W-1:0] RING_RESET = 5'd16;
  localparam logic [RING_W-1:0] RING_MIN = 5'd2;

  typedef enum logic [2:0] {
    EV_QUEUED   = 3'd0,
    EV_PARKED   = 3'd1,
    EV_GRANTED  = 3'd2,
    EV_RELEASED = 3'd3,
    EV_ERROR    = 3'd4
  } ev_code_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PARKED  = 2'd1,
    ST_QUEUED  = 2'd2,
    ST_HOLDING = 2'd3
  } seat_st_t;

  typedef enum logic {
    MODE_REQUEST = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  typedef struct packed {
    logic              mode;
    logic [SEAT_W-1:0] seat;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            event_res;
    logic [SEAT_W-1:0]     event_seat;
    logic [MEAL_OUT_W-1:0] meals;
    logic                  last;
  } out_item_t;

endpackage

[rtl/fork_waiter_arbiter.sv]
// One item at a time: in_stall stays high until the sequencer is back in idle. An error or
// parked result ends the item; a queued request or a release walks the admit queue, each
// grant reading the queue head and the meal memory of its seat, until the queue is empty or
// its head is blocked. Output stalls hold the sequencer.
// Reset is synchronous: control state, resources, seat status and meal valid bits
// clear at once; a cfg_we write clears the same state and loads the ring size from cfg_wdata.
// ----------------------------------------------------------------------------
// fork_waiter_arbiter
// Waiter arbiter for a ring of seats, each taking its own resource and its
// neighbor's. Admit and park FIFOs and meal counters live in memories.
// ----------------------------------------------------------------------------
module fork_waiter_arbiter
  import fwa_pkg::*;
#(
  parameter int NUM_SEATS = 16,
  parameter int MEAL_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [RING_W-1:0] cfg_wdata
);

  localparam int SW = $clog2(NUM_SEATS);
  localparam int CW = $clog2(NUM_SEATS + 1);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_DECIDE    = 6'b000010,
    S_WALK_RD   = 6'b000100,
    S_WALK_CHK  = 6'b001000,
    S_WALK_EMIT = 6'b010000,
    S_FINISH    = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [RING_W-1:0]   ring_r;
  logic [RING_W-1:0]   n_w;
  logic [NUM_SEATS-1:0] res_free_r, res_free_nxt;
  logic [RING_W-1:0]   holders_r, holders_nxt;
  seat_st_t            seat_st_r [NUM_SEATS];
  logic [NUM_SEATS-1:0] meal_vld_r;
  logic [MEAL_BITS-1:0] meal_mem [NUM_SEATS];
  logic [MEAL_BITS-1:0] meal_rd_r;
  logic                meal_rv_r;
  logic                meal_re;
  logic [SW-1:0]       meal_raddr;
  logic [MEAL_BITS-1:0] meal_cur, meal_inc;
  logic                meal_we;

  in_item_t            cur_r;
  logic [SW-1:0]       grant_seat_r;
  out_item_t           pend_r, out_r;
  logic                pend_vld_r, out_valid_r;
  logic                out_free, can_emit;
  logic                emit;
  out_item_t           emit_item;
  logic                flush_last;

  logic                adm_push, adm_pop, park_push, park_pop;
  logic [SEAT_W-1:0]   adm_push_data, adm_head, park_head;
  logic [CW-1:0]       adm_cnt, park_cnt;

  logic [SW-1:0]       sidx, pidx, hidx;
  logic                seat_ok, seat_has_cnt;
  logic [SW-1:0]       nb_seat, nb_head;
  logic [NUM_SEATS-1:0] need_seat, need_head;
  logic                st_seat_we, st_p_we, st_h_we;
  seat_st_t            st_seat_val;

  // effective ring size clamped to 2..NUM_SEATS
  always_comb begin
    n_w = ring_r;
    if (ring_r < RING_MIN) begin
      n_w = RING_MIN;
    end else if (ring_r > RING_W'(NUM_SEATS)) begin
      n_w = RING_W'(NUM_SEATS);
    end
  end

  // index helpers
  assign sidx         = cur_r.seat[SW-1:0];
  assign pidx         = park_head[SW-1:0];
  assign hidx         = adm_head[SW-1:0];
  assign seat_ok      = {1'b0, cur_r.seat} < n_w;
  assign seat_has_cnt = {1'b0, cur_r.seat} < RING_W'(NUM_SEATS);
  assign nb_seat      = (RING_W'(sidx) + RING_W'(1) == n_w) ? '0 : sidx + SW'(1);
  assign nb_head      = (RING_W'(hidx) + RING_W'(1) == n_w) ? '0 : hidx + SW'(1);
  assign need_seat    = ({{(NUM_SEATS-1){1'b0}}, 1'b1} << sidx)
                      | ({{(NUM_SEATS-1){1'b0}}, 1'b1} << nb_seat);
  assign need_head    = ({{(NUM_SEATS-1){1'b0}}, 1'b1} << hidx)
                      | ({{(NUM_SEATS-1){1'b0}}, 1'b1} << nb_head);

  // meal count of the read seat and its saturating increment
  assign meal_cur = meal_rv_r ? meal_rd_r : '0;
  assign meal_inc = (meal_cur == '1) ? meal_cur : meal_cur + MEAL_BITS'(1);

  function automatic logic [MEAL_OUT_W-1:0] meal_show(input logic [MEAL_BITS-1:0] c);
    logic [31:0] ext;
    ext = 32'(c);
    meal_show = (ext[31:MEAL_OUT_W] != '0) ? '1 : ext[MEAL_OUT_W-1:0];
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign can_emit = !pend_vld_r || out_free;
  assign in_stall = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    res_free_nxt  = res_free_r;
    holders_nxt   = holders_r;
    adm_push      = 1'b0;
    adm_push_data = cur_r.seat;
    adm_pop       = 1'b0;
    park_push     = 1'b0;
    park_pop      = 1'b0;
    meal_re       = 1'b0;
    meal_raddr    = in_data.seat[SW-1:0];
    meal_we       = 1'b0;
    emit          = 1'b0;
    emit_item     = '0;
    flush_last    = 1'b0;
    st_seat_we    = 1'b0;
    st_seat_val   = ST_IDLE;
    st_p_we       = 1'b0;
    st_h_we       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          meal_re   = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (can_emit) begin
          emit                 = 1'b1;
          emit_item.event_seat = cur_r.seat;
          emit_item.event_res  = EV_ERROR;
          emit_item.meals      = seat_has_cnt ? meal_show(meal_cur) : '0;
          state_nxt            = S_FINISH;
          if (seat_ok && cur_r.mode == MODE_REQUEST) begin
            if (seat_st_r[sidx] == ST_IDLE) begin
              st_seat_we = 1'b1;
              if (holders_r < n_w - RING_W'(1)) begin
                holders_nxt         = holders_r + RING_W'(1);
                adm_push            = 1'b1;
                st_seat_val         = ST_QUEUED;
                emit_item.event_res = EV_QUEUED;
                state_nxt           = S_WALK_RD;
              end else begin
                park_push           = 1'b1;
                st_seat_val         = ST_PARKED;
                emit_item.event_res = EV_PARKED;
              end
            end
          end else if (seat_ok && seat_st_r[sidx] == ST_HOLDING) begin
            // release: free both resources, count the meal, admit one parked seat
            res_free_nxt        = res_free_r | need_seat;
            meal_we             = 1'b1;
            st_seat_we          = 1'b1;
            st_seat_val         = ST_IDLE;
            emit_item.event_res = EV_RELEASED;
            emit_item.meals     = meal_show(meal_inc);
            if (park_cnt != '0) begin
              park_pop      = 1'b1;
              adm_push      = 1'b1;
              adm_push_data = park_head;
              st_p_we       = 1'b1;
            end else if (holders_r != '0) begin
              holders_nxt = holders_r - RING_W'(1);
            end
            state_nxt = S_WALK_RD;
          end
        end
      end
      S_WALK_RD: begin
        state_nxt = (adm_cnt == '0) ? S_FINISH : S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if ((res_free_r & need_head) == need_head) begin
          res_free_nxt = res_free_r & ~need_head;
          adm_pop      = 1'b1;
          st_h_we      = 1'b1;
          meal_re      = 1'b1;
          meal_raddr   = hidx;
          state_nxt    = S_WALK_EMIT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_WALK_EMIT: begin
        if (can_emit) begin
          emit                 = 1'b1;
          emit_item.event_res  = EV_GRANTED;
          emit_item.event_seat = SEAT_W'(grant_seat_r);
          emit_item.meals      = meal_show(meal_cur);
          state_nxt            = S_WALK_RD;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          flush_last = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers; a cfg_we write resets them but loads ring_r from cfg_wdata
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ring_r     <= RING_RESET;
      res_free_r <= '1;
      holders_r  <= '0;
      meal_vld_r <= '0;
      pend_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SEATS; i++) begin
        seat_st_r[i] <= ST_IDLE;
      end
    end else if (cfg_we) begin
      state_r    <= S_IDLE;
      ring_r     <= cfg_wdata;
      res_free_r <= '1;
      holders_r  <= '0;
      meal_vld_r <= '0;
      pend_vld_r <= 1'b0;
      out_valid_r <= out_valid_r && out_stall;
      for (int i = 0; i < NUM_SEATS; i++) begin
        seat_st_r[i] <= ST_IDLE;
      end
    end else begin
      state_r    <= state_nxt;
      res_free_r <= res_free_nxt;
      holders_r  <= holders_nxt;
      if (meal_we) begin
        meal_vld_r[sidx] <= 1'b1;
      end
      if (st_seat_we) begin
        seat_st_r[sidx] <= st_seat_val;
      end
      if (st_p_we) begin
        seat_st_r[pidx] <= ST_QUEUED;
      end
      if (st_h_we) begin
        seat_st_r[hidx] <= ST_HOLDING;
      end
      // pending event moves to the output once the next one or the end is known
      if ((emit && pend_vld_r) || flush_last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (emit) begin
        pend_vld_r <= 1'b1;
      end else if (flush_last) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cur_r <= in_data;
    end
    if (adm_pop) begin
      grant_seat_r <= hidx;
    end
    if (emit) begin
      pend_r <= emit_item;
    end
    if ((emit && pend_vld_r) || flush_last) begin
      out_r <= '{event_res: pend_r.event_res, event_seat: pend_r.event_seat,
                 meals: pend_r.meals, last: flush_last};
    end
  end

  // meal memory, read modify write
  always_ff @(posedge clk) begin
    if (meal_we && !cfg_we) begin
      meal_mem[sidx] <= meal_inc;
    end
    if (meal_re) begin
      meal_rd_r <= meal_mem[meal_raddr];
      meal_rv_r <= meal_vld_r[meal_raddr];
    end
  end

  fwa_queue #(.DEPTH(NUM_SEATS)) u_admit (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (cfg_we),
    .push      (adm_push),
    .push_data (adm_push_data),
    .pop       (adm_pop),
    .head_data (adm_head),
    .count     (adm_cnt)
  );

  fwa_queue #(.DEPTH(NUM_SEATS)) u_park (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (cfg_we),
    .push      (park_push),
    .push_data (cur_r.seat),
    .pop       (park_pop),
    .head_data (park_head),
    .count     (park_cnt)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_holders_limit: assert property (@(posedge clk) disable iff (!rst_n)
    holders_r < n_w)
    else $error("holders beyond ring limit");
  a_admit_in_holders: assert property (@(posedge clk) disable iff (!rst_n)
    RING_W'(adm_cnt) <= holders_r)
    else $error("admit queue larger than holders");
  a_finish_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINISH |-> pend_vld_r)
    else $error("finish without a pending event");
`endif

endmodule

[rtl/fwa_queue.sv]
// ----------------------------------------------------------------------------
// fwa_queue
// Seat FIFO in a synchronous memory; the head entry is read into a register
// every cycle, so a push or pop reaches head_data only after that read.
// ----------------------------------------------------------------------------
module fwa_queue
  import fwa_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr,
  input  logic                         push,
  input  logic [SEAT_W-1:0]            push_data,
  input  logic                         pop,
  output logic [SEAT_W-1:0]            head_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [SEAT_W-1:0] mem [DEPTH];
  logic [PW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [SEAT_W-1:0] rd_r;
  logic [PW:0]       tail_sum;
  logic [PW-1:0]     tail;
  logic              do_push;

  // tail position with wrap
  always_comb begin
    tail_sum = {1'b0, head_r} + (PW+1)'(cnt_r);
    if (tail_sum >= (PW+1)'(DEPTH)) begin
      tail_sum = tail_sum - (PW+1)'(DEPTH);
    end
    tail = tail_sum[PW-1:0];
  end

  assign do_push = push && (cnt_r < CW'(DEPTH));

  // pointer and fill count
  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (pop && cnt_r != '0) begin
      head_nxt = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + PW'(1);
      cnt_nxt  = cnt_nxt - CW'(1);
    end
    if (do_push) begin
      cnt_nxt = cnt_nxt + CW'(1);
    end
    if (clr) begin
      head_nxt = '0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // memory write and registered head read
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= push_data;
    end
    rd_r <= mem[head_r];
  end

  assign head_data = rd_r;
  assign count     = cnt_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !clr |-> cnt_r < CW'(DEPTH))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !clr |-> cnt_r != '0)
    else $error("pop from empty queue");
`endif

endmodule
